### design/rau_pkg.sv
`timescale 1ns / 1ps

package rau_pkg;

  // Default width of the fraction values.
  localparam int ValueWidthDefault = 32;

  // Number of cross products formed on the shared multiplier.
  localparam int MulCount = 4;
  localparam int MulIdxW  = $clog2(MulCount);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_INC = 3'd5,
    OP_DEC = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_equal;
    logic               is_less;
    status_t            status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FORM,
    S_GCD,
    S_DIV,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               load;
    logic               mul;
    logic [MulIdxW-1:0] mul_idx;
    logic               form;
    logic               gcd_step;
    logic               div_init;
    logic               div_step;
    logic               finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_den;
    logic reduce;
    logic gcd_done;
  } dp_sts_t;

endpackage

### design/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Channel  Signals                    Direction  Item
// req      req_valid, req_stall, req  in         op and two signed fractions
// rsp      rsp_valid, rsp_stall, rsp  out        reduced result, flags, status
//
// One item is worked on at a time. It passes through a load step, four cross
// products on the shared multiplier, a step that forms the numerator and
// denominator, the steps of the binary gcd and 2*VALUE_WIDTH restoring division
// steps. Items flagged with a zero denominator leave the multiplier step at once
// and finish, and those that need no reduction skip the gcd and the division.
// Reset is synchronous and clears the controller and the output valid.
// A finished result waits in the output register while rsp_stall is high;
// the next item is taken once the unit has handed its result over.
module rational_arithmetic_unit #(
  parameter int ValueWidth = rau_pkg::ValueWidthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  rau_pkg::in_item_t  req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rau_pkg::out_item_t rsp
);
  import rau_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  out_item_t result;
  logic      out_free;

  // The output register can take a new item when it is empty or draining.
  assign out_free = !rsp_valid || !rsp_stall;

  rau_ctrl #(
    .ValueWidth(ValueWidth)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  rau_dp #(
    .ValueWidth(ValueWidth)
  ) u_dp (
    .clk   (clk),
    .cmd   (cmd),
    .item  (req),
    .sts   (sts),
    .result(result)
  );

  // Output register: holds the result item until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) rsp <= result;
  end

`ifndef SYNTHESIS
  // Once an item is taken the unit is busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("unit took a second item straight after the first");

  // Any error status comes with the result 0/1.
  a_error_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> (rsp.res_num == 0 && rsp.res_den == 31'd1))
    else $error("error status with a result other than 0/1");

  // A zero denominator gives no comparison flags.
  a_zero_den_flags: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_ZERO_DEN) |-> (!rsp.is_equal && !rsp.is_less))
    else $error("flags set with a zero denominator");

  // Equal and less than never hold together, and the denominator is positive.
  a_flags_den: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!(rsp.is_equal && rsp.is_less) && rsp.res_den != '0))
    else $error("inconsistent flags or zero denominator in result");
`endif

endmodule

### design/rau_ctrl.sv
`timescale 1ns / 1ps

module rau_ctrl #(
  parameter int ValueWidth = rau_pkg::ValueWidthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                out_free,
  input  rau_pkg::dp_sts_t    sts,
  output rau_pkg::ctrl_cmd_t  cmd
);
  import rau_pkg::*;

  localparam int MagWidth = 2 * ValueWidth;
  localparam int DivCntW  = $clog2(MagWidth);

  state_t             state;
  state_t             state_next;
  logic [MulIdxW-1:0] mul_cnt;
  logic [DivCntW-1:0] div_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mul_cnt <= '0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      mul_cnt <= (state == S_MUL) ? mul_cnt + 1'b1 : '0;
      div_cnt <= (state == S_DIV) ? div_cnt + 1'b1 : '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_MUL;
      end
      S_MUL: begin
        if (sts.zero_den) state_next = S_DONE;
        else if (mul_cnt == MulIdxW'(MulCount - 1)) state_next = S_FORM;
      end
      S_FORM: begin
        state_next = sts.reduce ? S_GCD : S_DONE;
      end
      S_GCD: begin
        if (sts.gcd_done) state_next = S_DIV;
      end
      S_DIV: begin
        if (div_cnt == DivCntW'(MagWidth - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = (state != S_IDLE);
    case (state)
      S_IDLE: cmd.load = req_valid;
      S_MUL: begin
        cmd.mul     = !sts.zero_den;
        cmd.mul_idx = mul_cnt;
      end
      S_FORM: cmd.form = 1'b1;
      S_GCD: begin
        cmd.div_init = sts.gcd_done;
        cmd.gcd_step = !sts.gcd_done;
      end
      S_DIV:  cmd.div_step = 1'b1;
      S_DONE: cmd.finish = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

### design/rau_dp.sv
`timescale 1ns / 1ps

module rau_dp #(
  parameter int ValueWidth = rau_pkg::ValueWidthDefault
) (
  input  logic                clk,
  input  rau_pkg::ctrl_cmd_t  cmd,
  input  rau_pkg::in_item_t   item,
  output rau_pkg::dp_sts_t    sts,
  output rau_pkg::out_item_t  result
);
  import rau_pkg::*;

  localparam int W  = ValueWidth;
  localparam int MW = 2 * ValueWidth;
  localparam logic [MW-1:0] Half = MW'(1) << (W - 1);

  function automatic logic [W-1:0] abs_w(input logic [W-1:0] x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  // Operands in sign and magnitude form, denominators made positive.
  op_t           op_q;
  logic          a_neg;
  logic          b_neg;
  logic [W-1:0]  a_mag;
  logic [W-1:0]  ad_mag;
  logic [W-1:0]  b_mag;
  logic [W-1:0]  bd_mag;
  logic [MW-1:0] prod [MulCount];
  status_t       status_q;
  logic          have_q;
  logic          eq_q;
  logic          lt_q;
  logic          num_neg;
  logic [MW-1:0] u;
  logic [MW-1:0] v;
  logic [MW-1:0] n;
  logic [MW-1:0] d;
  logic [MW-1:0] rem_n;
  logic [MW-1:0] rem_d;

  // Load decode.
  logic [W-1:0] an_w, ad_w, bn_w, bd_w;
  logic         zero_den;
  logic         op_known;
  logic [W-1:0] b_mag_in;

  always_comb begin
    an_w     = item.a_num[W-1:0];
    ad_w     = item.a_den[W-1:0];
    bn_w     = item.b_num[W-1:0];
    bd_w     = item.b_den[W-1:0];
    zero_den = (ad_w == '0) || (bd_w == '0);
    b_mag_in = abs_w(bn_w);
    case (item.op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG, OP_INC, OP_DEC: op_known = 1'b1;
      default: op_known = 1'b0;
    endcase
  end

  // Shared multiplier.
  logic [W-1:0]  mul_x;
  logic [W-1:0]  mul_y;
  logic [MW-1:0] mul_p;

  always_comb begin
    case (cmd.mul_idx)
      2'd0: begin mul_x = a_mag;  mul_y = bd_mag; end
      2'd1: begin mul_x = b_mag;  mul_y = ad_mag; end
      2'd2: begin mul_x = ad_mag; mul_y = bd_mag; end
      default: begin mul_x = a_mag; mul_y = b_mag; end
    endcase
    mul_p = MW'(mul_x) * MW'(mul_y);
  end

  // Numerator and denominator before reduction.
  logic          x_neg, y_neg, s_neg;
  logic [MW-1:0] x_mag, y_mag, s_mag, den_f;
  logic          eq_f, lt_f;

  always_comb begin
    x_neg = 1'b0;
    x_mag = '0;
    y_neg = 1'b0;
    y_mag = '0;
    den_f = prod[2];
    case (op_q)
      OP_ADD: begin
        x_neg = a_neg; x_mag = prod[0];
        y_neg = b_neg; y_mag = prod[1];
      end
      OP_SUB: begin
        x_neg = a_neg; x_mag = prod[0];
        y_neg = !b_neg && (prod[1] != '0); y_mag = prod[1];
      end
      OP_MUL: begin
        x_neg = a_neg ^ b_neg; x_mag = prod[3];
      end
      OP_DIV: begin
        x_neg = a_neg ^ b_neg; x_mag = prod[0];
        den_f = prod[1];
      end
      OP_NEG: begin
        x_neg = !a_neg; x_mag = MW'(a_mag);
        den_f = MW'(ad_mag);
      end
      OP_INC: begin
        x_neg = a_neg; x_mag = MW'(a_mag);
        y_mag = MW'(ad_mag);
        den_f = MW'(ad_mag);
      end
      OP_DEC: begin
        x_neg = a_neg; x_mag = MW'(a_mag);
        y_neg = 1'b1; y_mag = MW'(ad_mag);
        den_f = MW'(ad_mag);
      end
      default: den_f = prod[2];
    endcase

    if (x_neg == y_neg) begin
      s_mag = x_mag + y_mag;
      s_neg = x_neg;
    end else if (x_mag >= y_mag) begin
      s_mag = x_mag - y_mag;
      s_neg = x_neg;
    end else begin
      s_mag = y_mag - x_mag;
      s_neg = y_neg;
    end
    if (s_mag == '0) s_neg = 1'b0;

    // The cross products compare the two fractions.
    eq_f = (a_neg == b_neg) && (prod[0] == prod[1]);
    lt_f = (a_neg && !b_neg) || (!a_neg && !b_neg && (prod[0] < prod[1])) ||
           (a_neg && b_neg && (prod[0] > prod[1]));
  end

  // Division lanes: one restoring step per cycle for each quotient.
  logic [MW:0]   sh_n, sh_d;
  logic          ge_n, ge_d;

  always_comb begin
    sh_n = {rem_n, n[MW-1]};
    sh_d = {rem_d, d[MW-1]};
    ge_n = sh_n >= {1'b0, u};
    ge_d = sh_d >= {1'b0, u};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= item.op;
      a_neg  <= (an_w[W-1] ^ ad_w[W-1]) && (an_w != '0);
      b_neg  <= (bn_w[W-1] ^ bd_w[W-1]) && (bn_w != '0);
      a_mag  <= abs_w(an_w);
      ad_mag <= abs_w(ad_w);
      b_mag  <= b_mag_in;
      bd_mag <= abs_w(bd_w);
      eq_q   <= 1'b0;
      lt_q   <= 1'b0;
      if (zero_den) begin
        status_q <= ST_ZERO_DEN;
      end else if (item.op == OP_DIV && b_mag_in == '0) begin
        status_q <= ST_DIV_ZERO;
      end else begin
        status_q <= ST_OK;
      end
      have_q <= !zero_den && op_known && !(item.op == OP_DIV && b_mag_in == '0);
    end
    if (cmd.mul) prod[cmd.mul_idx] <= mul_p;
    if (cmd.form) begin
      num_neg <= s_neg;
      eq_q    <= eq_f;
      lt_q    <= lt_f;
      u       <= s_mag;
      n       <= s_mag;
      v       <= den_f;
      d       <= den_f;
    end
    if (cmd.gcd_step) begin
      if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        n <= n >> 1;
        d <= d >> 1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u >= v) begin
        u <= u - v;
      end else begin
        v <= v - u;
      end
    end
    if (cmd.div_init) begin
      u     <= u | v;
      rem_n <= '0;
      rem_d <= '0;
    end
    if (cmd.div_step) begin
      rem_n <= ge_n ? MW'(sh_n - {1'b0, u}) : sh_n[MW-1:0];
      rem_d <= ge_d ? MW'(sh_d - {1'b0, u}) : sh_d[MW-1:0];
      n     <= {n[MW-2:0], ge_n};
      d     <= {d[MW-2:0], ge_d};
    end
  end

  // Range check and final result.
  logic          fits;
  logic [MW-1:0] sval;

  always_comb begin
    fits = (d <= Half - 1'b1) && (num_neg ? (n <= Half) : (n <= Half - 1'b1));
    sval = num_neg ? (~n + 1'b1) : n;
    result.is_equal = eq_q;
    result.is_less  = lt_q;
    result.status   = status_q;
    result.res_num  = '0;
    result.res_den  = 31'd1;
    if (have_q) begin
      if (fits) begin
        result.res_num = 32'(signed'(sval[W-1:0]));
        result.res_den = 31'(d);
      end else begin
        result.status = ST_OVERFLOW;
      end
    end
  end

  assign sts.zero_den = (status_q == ST_ZERO_DEN);
  assign sts.reduce   = have_q;
  assign sts.gcd_done = (u == '0) || (v == '0);

endmodule
